### rtl/fpu_pkg.sv
// Shared types and constants of the single-precision add/sub/mul/div unit.
// No dependencies.
`default_nettype none
package fpu_pkg;

  localparam logic [31:0] QNAN_WORD = 32'h7FC0_0000;
  localparam logic [31:0] INF_WORD  = 32'h7F80_0000;
  localparam logic [31:0] SIGN_WORD = 32'h8000_0000;
  localparam logic [7:0]  HALF_RND  = 8'h80;
  localparam int unsigned JAM_MAX   = 32;

  typedef logic signed [9:0] fexp_t;

  localparam fexp_t EMIN = -10'sd126;
  localparam fexp_t EMAX = 10'sd127;
  localparam fexp_t BIAS = 10'sd127;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef struct packed {
    logic        neg;
    fexp_t       exp;
    logic [23:0] mant;
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
  } unpack_t;

  typedef struct packed {
    logic start;
    logic x_small;   // dividend significand below divisor: one extra shift
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic        sticky;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/fpu_req_if.sv
// Request channel: operation code and two binary32 operands.
// Depends on nothing.
`default_nettype none
interface fpu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

### rtl/fpu_rsp_if.sv
// Response channel: one rounded binary32 result word.
// Depends on nothing.
`default_nettype none
interface fpu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;

  modport source (output valid, result_word, input ready);
  modport sink   (input valid, result_word, output ready);
endinterface
`default_nettype wire

### rtl/fpu_unpack.sv
// Splits a binary32 word into sign, unbiased exponent, significand and class.
// Depends on fpu_pkg.
`default_nettype none
module fpu_unpack (
  input  logic [31:0]      word_i,
  output fpu_pkg::unpack_t fields_o
);
  import fpu_pkg::*;

  logic [7:0]  ef;
  logic [22:0] fr;

  assign ef = word_i[30:23];
  assign fr = word_i[22:0];

  always_comb begin
    fields_o.neg     = word_i[31];
    fields_o.is_nan  = (ef == 8'hFF) && (fr != 23'd0);
    fields_o.is_inf  = (ef == 8'hFF) && (fr == 23'd0);
    fields_o.is_zero = (ef == 8'h00) && (fr == 23'd0);
    // subnormals keep the minimum exponent and are normalized later
    if (ef == 8'h00) begin
      fields_o.mant = {1'b0, fr};
      fields_o.exp  = EMIN;
    end else begin
      fields_o.mant = {1'b1, fr};
      fields_o.exp  = fexp_t'({2'b00, ef}) - BIAS;
    end
  end
endmodule
`default_nettype wire

### rtl/fpu_div_unit.sv
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// Depends on fpu_pkg.
`default_nettype none
module fpu_div_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpu_pkg::div_req_t req_i,
  input  logic [23:0]       x_mant_i,
  input  logic [23:0]       y_mant_i,
  output fpu_pkg::div_rsp_t rsp_o
);
  import fpu_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [25:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic        sticky_q, sticky_d;
  logic        ge;
  logic [25:0] rem_new;

  // remainder stays below twice the divisor
  assign ge      = rem_q >= {2'b00, y_mant_i};
  assign rem_new = ge ? rem_q - {2'b00, y_mant_i} : rem_q;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    sticky_d = sticky_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      rem_d  = req_i.x_small ? {1'b0, x_mant_i, 1'b0} : {2'b00, x_mant_i};
      quo_d  = '0;
    end else if (busy_q) begin
      quo_d    = {quo_q[30:0], ge};
      rem_d    = {rem_new[24:0], 1'b0};
      sticky_d = rem_new != 26'd0;
      cnt_d    = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    sticky_q <= sticky_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quo    = quo_q;
  assign rsp_o.sticky = sticky_q;
endmodule
`default_nettype wire

### rtl/fp32_add_sub_mul_div_unit.sv
// Top level of the binary32 add/sub/mul/div unit: sequencer and datapath.
// Depends on fpu_pkg, fpu_req_if, fpu_rsp_if, fpu_unpack, fpu_div_unit.
// One operation at a time: req is ready only when idle, and the result is held
// on rsp until taken. Special cases go straight from the check to the output;
// add/sub shift the smaller significand right one bit per step over the exponent
// difference (up to 32) and renormalize a cancellation one bit per step; multiply
// forms one 24x24 product; divide runs the 32-step restoring divider. Subnormal
// operands take one normalizing shift per leading zero, and subnormal results one
// shift per bit of denormalizing shift (up to 32). Rounding is nearest-even; NaNs come
// back as 0x7FC00000; no flags.
`default_nettype none
module fp32_add_sub_mul_div_unit (
  input  wire     clk_i,
  input  wire     rst_ni,
  fpu_req_if.sink   req_i,
  fpu_rsp_if.source rsp_o
);
  import fpu_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_NORM  = 13'b0000000000010,
    S_SPEC  = 13'b0000000000100,
    S_ALIGN = 13'b0000000001000,
    S_ADD   = 13'b0000000010000,
    S_LZ    = 13'b0000000100000,
    S_MUL   = 13'b0000001000000,
    S_MULJ  = 13'b0000010000000,
    S_DIV   = 13'b0000100000000,
    S_RCHK  = 13'b0001000000000,
    S_RSH   = 13'b0010000000000,
    S_ROUND = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e      state_q, state_d;
  kind_e       kind_q, kind_d;
  logic [31:0] a_word_q, a_word_d, b_word_q, b_word_d;
  unpack_t     ua_q, ua_d, ub_q, ub_d;
  logic [31:0] xv_q, xv_d, yv_q, yv_d;
  logic        xneg_q, xneg_d, yneg_q, yneg_d;
  logic [47:0] v_q, v_d;
  fexp_t       e_q, e_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] res_q, res_d;

  logic [31:0] b_eff;
  unpack_t     ua_in, ub_in;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign b_eff = (kind_e'(req_i.kind) == KIND_SUB) ? (req_i.operand_b ^ SIGN_WORD)
                                                   : req_i.operand_b;

  fpu_unpack u_unpack_a (.word_i(req_i.operand_a), .fields_o(ua_in));
  fpu_unpack u_unpack_b (.word_i(b_eff),           .fields_o(ub_in));

  fpu_div_unit u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (div_req),
    .x_mant_i (ua_q.mant),
    .y_mant_i (ub_q.mant),
    .rsp_o    (div_rsp)
  );

  // shared helpers
  logic        na_sh, nb_sh;
  logic        pneg;
  logic        spec_hit;
  logic [31:0] spec_word;
  logic signed [10:0] ediff, udiff;
  logic [32:0] sum33;
  logic [7:0]  rnd_low;
  logic [24:0] m_inc;
  logic [23:0] m_fin;
  fexp_t       e_fin;
  logic        rnd_up;

  assign na_sh = !ua_q.mant[23] && (ua_q.mant != 24'd0);
  assign nb_sh = !ub_q.mant[23] && (ub_q.mant != 24'd0);
  assign pneg  = ua_q.neg ^ ub_q.neg;
  assign ediff = 11'(ua_q.exp) - 11'(ub_q.exp);
  assign udiff = 11'(EMIN) - 11'(e_q);
  assign sum33 = {1'b0, xv_q} + {1'b0, yv_q};

  assign rnd_low = v_q[7:0];
  assign rnd_up  = (rnd_low > HALF_RND) || ((rnd_low == HALF_RND) && v_q[8]);
  assign m_inc   = {1'b0, v_q[31:8]} + {24'd0, rnd_up};
  assign m_fin   = m_inc[24] ? m_inc[24:1] : m_inc[23:0];
  assign e_fin   = m_inc[24] ? e_q + 10'sd1 : e_q;

  always_comb begin
    spec_hit  = 1'b1;
    spec_word = QNAN_WORD;
    case (kind_q)
      KIND_ADD, KIND_SUB: begin
        if (ua_q.is_nan || ub_q.is_nan) spec_word = QNAN_WORD;
        else if (ua_q.is_inf || ub_q.is_inf) begin
          if (ua_q.is_inf && ub_q.is_inf && (ua_q.neg != ub_q.neg)) spec_word = QNAN_WORD;
          else if (ua_q.is_inf) spec_word = {ua_q.neg, INF_WORD[30:0]};
          else spec_word = {ub_q.neg, INF_WORD[30:0]};
        end
        else if (ua_q.is_zero) spec_word = b_word_q;
        else if (ub_q.is_zero) spec_word = a_word_q;
        else spec_hit = 1'b0;
      end
      KIND_MUL: begin
        if (ua_q.is_nan || ub_q.is_nan) spec_word = QNAN_WORD;
        else if (ua_q.is_inf || ub_q.is_inf) begin
          if (ua_q.is_zero || ub_q.is_zero) spec_word = QNAN_WORD;
          else spec_word = {pneg, INF_WORD[30:0]};
        end
        else if (ua_q.is_zero || ub_q.is_zero) spec_word = {pneg, 31'd0};
        else spec_hit = 1'b0;
      end
      KIND_DIV: begin
        if (ua_q.is_nan || ub_q.is_nan) spec_word = QNAN_WORD;
        else if (ua_q.is_inf && ub_q.is_inf) spec_word = QNAN_WORD;
        else if (ua_q.is_zero && ub_q.is_zero) spec_word = QNAN_WORD;
        else if (ua_q.is_inf) spec_word = {pneg, INF_WORD[30:0]};
        else if (ub_q.is_inf) spec_word = {pneg, 31'd0};
        else if (ub_q.is_zero) spec_word = {pneg, INF_WORD[30:0]};
        else if (ua_q.is_zero) spec_word = {pneg, 31'd0};
        else spec_hit = 1'b0;
      end
      default: spec_hit = 1'b1;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    a_word_d = a_word_q;
    b_word_d = b_word_q;
    ua_d     = ua_q;
    ub_d     = ub_q;
    xv_d     = xv_q;
    yv_d     = yv_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    v_d      = v_q;
    e_d      = e_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    res_d    = res_q;
    div_req  = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d   = kind_e'(req_i.kind);
          a_word_d = req_i.operand_a;
          b_word_d = b_eff;
          ua_d     = ua_in;
          ub_d     = ub_in;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        // one bit per cycle for subnormal significands
        if (na_sh) begin
          ua_d.mant = {ua_q.mant[22:0], 1'b0};
          ua_d.exp  = ua_q.exp - 10'sd1;
        end
        if (nb_sh) begin
          ub_d.mant = {ub_q.mant[22:0], 1'b0};
          ub_d.exp  = ub_q.exp - 10'sd1;
        end
        if (!na_sh && !nb_sh) state_d = S_SPEC;
      end
      S_SPEC: begin
        neg_d = pneg;
        if (spec_hit) begin
          res_d   = spec_word;
          state_d = S_OUT;
        end else begin
          case (kind_q)
            KIND_ADD, KIND_SUB: begin
              // larger exponent goes to x; the smaller one is jammed right
              if (ediff >= 11'sd0) begin
                xv_d   = {ua_q.mant, 8'd0};
                yv_d   = {ub_q.mant, 8'd0};
                xneg_d = ua_q.neg;
                yneg_d = ub_q.neg;
                e_d    = ua_q.exp;
                cnt_d  = (ediff > 11'sd32) ? 6'(JAM_MAX) : ediff[5:0];
              end else begin
                xv_d   = {ub_q.mant, 8'd0};
                yv_d   = {ua_q.mant, 8'd0};
                xneg_d = ub_q.neg;
                yneg_d = ua_q.neg;
                e_d    = ub_q.exp;
                cnt_d  = (ediff < -11'sd32) ? 6'(JAM_MAX) : 6'(-ediff);
              end
              state_d = S_ALIGN;
            end
            KIND_MUL: begin
              state_d = S_MUL;
            end
            default: begin
              div_req.start   = 1'b1;
              div_req.x_small = ua_q.mant < ub_q.mant;
              e_d = ua_q.exp - ub_q.exp - ((ua_q.mant < ub_q.mant) ? 10'sd1 : 10'sd0);
              state_d = S_DIV;
            end
          endcase
        end
      end
      S_ALIGN: begin
        if (cnt_q != 6'd0) begin
          yv_d  = {1'b0, yv_q[31:1]} | {31'd0, yv_q[0]};
          cnt_d = cnt_q - 6'd1;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (xneg_q == yneg_q) begin
          neg_d = xneg_q;
          if (sum33[32]) begin
            v_d = {16'd0, sum33[32:1] | {31'd0, sum33[0]}};
            e_d = e_q + 10'sd1;
          end else begin
            v_d = {16'd0, sum33[31:0]};
          end
          state_d = S_RCHK;
        end else if (xv_q == yv_q) begin
          res_d   = 32'd0;
          state_d = S_OUT;
        end else if (xv_q > yv_q) begin
          neg_d   = xneg_q;
          v_d     = {16'd0, xv_q - yv_q};
          state_d = S_LZ;
        end else begin
          neg_d   = yneg_q;
          v_d     = {16'd0, yv_q - xv_q};
          state_d = S_LZ;
        end
      end
      S_LZ: begin
        if (!v_q[31]) begin
          v_d = {v_q[46:0], 1'b0};
          e_d = e_q - 10'sd1;
        end else begin
          state_d = S_RCHK;
        end
      end
      S_MUL: begin
        v_d     = ua_q.mant * ub_q.mant;
        e_d     = ua_q.exp + ub_q.exp;
        state_d = S_MULJ;
      end
      S_MULJ: begin
        if (v_q[47]) begin
          v_d = {16'd0, v_q[47:16] | {31'd0, v_q[15:0] != 16'd0}};
          e_d = e_q + 10'sd1;
        end else begin
          v_d = {16'd0, v_q[46:15] | {31'd0, v_q[14:0] != 15'd0}};
        end
        state_d = S_RCHK;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          v_d     = {16'd0, div_rsp.quo | {31'd0, div_rsp.sticky}};
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (e_q < EMIN) begin
          cnt_d   = (udiff > 11'sd32) ? 6'(JAM_MAX) : udiff[5:0];
          e_d     = EMIN;
          state_d = S_RSH;
        end else begin
          state_d = S_ROUND;
        end
      end
      S_RSH: begin
        if (cnt_q != 6'd0) begin
          v_d   = {1'b0, v_q[47:1]} | {47'd0, v_q[0]};
          cnt_d = cnt_q - 6'd1;
        end else begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (e_fin > EMAX) res_d = {neg_q, INF_WORD[30:0]};
        else if (m_fin == 24'd0) res_d = {neg_q, 31'd0};
        else if ((e_fin == EMIN) && !m_fin[23]) res_d = {neg_q, 8'd0, m_fin[22:0]};
        else res_d = {neg_q, 8'(e_fin + BIAS), m_fin[22:0]};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    a_word_q <= a_word_d;
    b_word_q <= b_word_d;
    ua_q     <= ua_d;
    ub_q     <= ub_d;
    xv_q     <= xv_d;
    yv_q     <= yv_d;
    xneg_q   <= xneg_d;
    yneg_q   <= yneg_d;
    v_q      <= v_d;
    e_q      <= e_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
  end

  assign req_i.ready       = state_q == S_IDLE;
  assign rsp_o.valid       = state_q == S_OUT;
  assign rsp_o.result_word = res_q;
endmodule
`default_nettype wire

### tb/fp32_add_sub_mul_div_unit_tb.sv
// Testbench of the binary32 add/sub/mul/div unit: directed corner cases, then random traffic
// under several idle/stall phases; results checked in order against a bit-exact predictor.
// Depends on fpu_pkg, fpu_req_if, fpu_rsp_if and the unit's RTL.
`timescale 1ns / 100ps
module fp32_add_sub_mul_div_unit_tb;
  import fpu_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] a;
    logic [31:0] b;
  } fop_t;

  typedef struct {
    logic        neg;
    int          e;
    logic [23:0] mant;
    bit          zero;
    bit          inf;
    bit          nan;
  } fsplit_t;

  logic clk_i;
  logic rst_ni;

  fpu_req_if req_if ();
  fpu_rsp_if rsp_if ();

  fp32_add_sub_mul_div_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  fop_t        op_q[$];
  logic [31:0] expected_q[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          mismatches;
  int          cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] jam(logic [63:0] v, int n);
    if (n <= 0) return v;
    if (n < 64) return (v >> n) | {63'd0, |(v & ((64'd1 << n) - 64'd1))};
    return {63'd0, |v};
  endfunction

  function automatic fsplit_t split(logic [31:0] w);
    fsplit_t p;
    p.neg = w[31];
    p.e = 0;
    p.mant = '0;
    p.zero = 0;
    p.inf = 0;
    p.nan = 0;
    if (w[30:23] == 8'hFF) begin
      p.inf = (w[22:0] == 0);
      p.nan = (w[22:0] != 0);
    end else if (w[30:23] == 0) begin
      p.e = -126;
      if (w[22:0] == 0) begin
        p.zero = 1;
      end else begin
        p.mant = {1'b0, w[22:0]};
        while (!p.mant[23]) begin
          p.mant = p.mant << 1;
          p.e--;
        end
      end
    end else begin
      p.e = int'(w[30:23]) - 127;
      p.mant = {1'b1, w[22:0]};
    end
    return p;
  endfunction

  function automatic logic [31:0] round_to_word(logic neg, int e, logic [63:0] v);
    logic [63:0] m;
    logic [7:0]  low;
    if (e < -126) begin
      v = jam(v, -126 - e);
      e = -126;
    end
    low = v[7:0];
    m = v >> 8;
    if (low > HALF_RND || (low == HALF_RND && m[0])) m++;
    if (m >= 64'h100_0000) begin
      m = m >> 1;
      e++;
    end
    if (e > 127) return {neg, 31'd0} | INF_WORD;
    if (m == 0) return {neg, 31'd0};
    if (e == -126 && m < 64'h80_0000) return {neg, 8'd0, m[22:0]};
    return {neg, 8'(e + 127), m[22:0]};
  endfunction

  function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
    fsplit_t     x, y;
    logic [63:0] xv, yv, s;
    int          e;
    logic        neg;
    x = split(a);
    y = split(b);
    if (x.nan || y.nan) return QNAN_WORD;
    if (x.inf || y.inf) begin
      if (x.inf && y.inf && x.neg != y.neg) return QNAN_WORD;
      return {x.inf ? x.neg : y.neg, 31'd0} | INF_WORD;
    end
    if (x.zero) return b;
    if (y.zero) return a;
    xv = 64'(x.mant) << 8;
    yv = 64'(y.mant) << 8;
    e = x.e;
    if (x.e > y.e) begin
      yv = jam(yv, x.e - y.e);
    end else if (y.e > x.e) begin
      xv = jam(xv, y.e - x.e);
      e = y.e;
    end
    if (x.neg == y.neg) begin
      s = xv + yv;
      neg = x.neg;
      if (s[32]) begin
        s = jam(s, 1);
        e++;
      end
    end else begin
      if (xv == yv) return 32'd0;
      if (xv > yv) begin
        s = xv - yv;
        neg = x.neg;
      end else begin
        s = yv - xv;
        neg = y.neg;
      end
      while (!s[31]) begin
        s = s << 1;
        e--;
      end
    end
    return round_to_word(neg, e, s);
  endfunction

  function automatic logic [31:0] predict_product(logic [31:0] a, logic [31:0] b);
    fsplit_t     x, y;
    logic        neg;
    logic [63:0] pr;
    x = split(a);
    y = split(b);
    neg = x.neg ^ y.neg;
    if (x.nan || y.nan) return QNAN_WORD;
    if (x.inf || y.inf) begin
      if (x.zero || y.zero) return QNAN_WORD;
      return {neg, 31'd0} | INF_WORD;
    end
    if (x.zero || y.zero) return {neg, 31'd0};
    pr = 64'(x.mant) * 64'(y.mant);
    if (pr[47]) return round_to_word(neg, x.e + y.e + 1, jam(pr, 16));
    return round_to_word(neg, x.e + y.e, jam(pr, 15));
  endfunction

  function automatic logic [31:0] predict_quotient(logic [31:0] a, logic [31:0] b);
    fsplit_t     x, y;
    logic        neg;
    int          e;
    logic [63:0] num, q;
    x = split(a);
    y = split(b);
    neg = x.neg ^ y.neg;
    e = x.e - y.e;
    if (x.nan || y.nan) return QNAN_WORD;
    if ((x.inf && y.inf) || (x.zero && y.zero)) return QNAN_WORD;
    if (x.inf || y.zero) return {neg, 31'd0} | INF_WORD;
    if (y.inf || x.zero) return {neg, 31'd0};
    if (x.mant >= y.mant) begin
      num = 64'(x.mant) << 31;
    end else begin
      num = 64'(x.mant) << 32;
      e--;
    end
    q = num / 64'(y.mant);
    if (num % 64'(y.mant) != 0) q[0] = 1'b1;
    return round_to_word(neg, e, q);
  endfunction

  function automatic logic [31:0] predict_result(fop_t op);
    case (op.kind)
      KIND_ADD: return predict_sum(op.a, op.b);
      KIND_SUB: return predict_sum(op.a, op.b ^ SIGN_WORD);
      KIND_MUL: return predict_product(op.a, op.b);
      default:  return predict_quotient(op.a, op.b);
    endcase
  endfunction

  // Random operand biased toward interesting exponents and significands.
  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hFF;
      2: w[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
      3: w[30:23] = $urandom_range(0, 1) ? 8'(1 + $urandom_range(0, 3))
                                         : 8'(254 - $urandom_range(0, 3));
      4: w[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
      5: w[22:0] = 23'(w[22:0] >> $urandom_range(0, 22));
      default: ;
    endcase
    return w;
  endfunction

  task automatic push_op(kind_e k, logic [31:0] a, logic [31:0] b);
    fop_t op;
    op.kind = k;
    op.a = a;
    op.b = b;
    op_q.push_back(op);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.kind      <= KIND_ADD;
      req_if.operand_a <= '0;
      req_if.operand_b <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) expected_q.push_back(predict_result(
          fop_t'{kind_e'(req_if.kind), req_if.operand_a, req_if.operand_b}));
      if (op_q.size() > 0 && !hold_off && $urandom_range(0, 99) >= send_idle_pct) begin
        fop_t op;
        op = op_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.kind      <= op.kind;
        req_if.operand_a <= op.a;
        req_if.operand_b <= op.b;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", rsp_if.result_word);
        end else begin
          logic [31:0] exp_w;
          exp_w = expected_q.pop_front();
          if (rsp_if.result_word !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h got %h", exp_w, rsp_if.result_word);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 1_000_000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (op_q.size() > 0 || req_if.valid || expected_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      logic [31:0] a, b;
      a = rand_operand();
      b = rand_operand();
      // Near-cancellation pairs for deep renormalization.
      if ($urandom_range(0, 7) == 0) b = a ^ SIGN_WORD ^ 32'($urandom_range(0, 3));
      push_op(kind_e'($urandom_range(0, 3)), a, b);
    end
    wait_drained();
  endtask

  initial begin
    logic [31:0] corner[10];
    mismatches = 0;
    cycle_cnt = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
               32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
               32'h3F80_0000, 32'hFFFF_FFFF};
    push_op(KIND_ADD, 32'h7F80_0000, 32'hFF80_0000);   // inf - inf
    push_op(KIND_SUB, 32'h7F80_0000, 32'h7F80_0000);
    push_op(KIND_MUL, 32'h0000_0000, 32'hFF80_0000);   // zero * inf
    push_op(KIND_DIV, 32'h8000_0000, 32'h0000_0000);   // zero / zero
    push_op(KIND_DIV, 32'h7F80_0000, 32'hFF80_0000);   // inf / inf
    push_op(KIND_DIV, 32'h3F80_0000, 32'h8000_0000);   // x / zero
    push_op(KIND_DIV, 32'h4000_0000, 32'h7F80_0000);   // x / inf
    push_op(KIND_SUB, 32'h0000_0000, 32'h4049_0FDB);   // zero minus b
    push_op(KIND_ADD, 32'h3F80_0000, 32'hBF80_0000);   // exact cancellation
    push_op(KIND_MUL, 32'h7F7F_FFFF, 32'h4000_0000);   // overflow
    push_op(KIND_MUL, 32'h0080_0000, 32'h3F00_0000);   // underflow to subnormal
    push_op(KIND_MUL, 32'h0000_0001, 32'h3F00_0000);   // rounds to zero
    push_op(KIND_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    push_op(KIND_DIV, 32'h0000_0001, 32'h7F7F_FFFF);
    push_op(KIND_ADD, 32'h4B80_0000, 32'h3F80_0000);   // tie to even
    for (int i = 0; i < 10; i++)
      push_op(kind_e'(i % 4), corner[i], corner[9 - i]);
    wait_drained();

    run_phase(300, 0, 0);
    // Hold the sender off with one divide queued, then release it and drain.
    hold_off = 1;
    push_op(KIND_DIV, 32'h3F80_0000, 32'h4040_0000);
    repeat (20) @(posedge clk_i);
    hold_off = 0;
    wait_drained();
    run_phase(250, 79, 0);
    run_phase(250, 0, 79);
    run_phase(300, 34, 34);
    repeat (100) @(posedge clk_i);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/fpu_pkg.sv
rtl/fpu_req_if.sv
rtl/fpu_rsp_if.sv
rtl/fpu_unpack.sv
rtl/fpu_div_unit.sv
rtl/fp32_add_sub_mul_div_unit.sv
tb/fp32_add_sub_mul_div_unit_tb.sv
